/* hw/rtl/mhc_pkg.sv */
// shared types and constants for the moisture hysteresis controller
// no dependencies; imported by every module of the block
package mhc_pkg;

    localparam int APB_AW = 4;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_LOW  = 2'd1;
    localparam logic [1:0] REG_MID  = 2'd2;
    localparam logic [1:0] REG_HIGH = 2'd3;

    localparam logic [1:0] MODE_MANUAL   = 2'd0;
    localparam logic [1:0] MODE_HUMIDITY = 2'd1;

    localparam logic [6:0] RST_LOW  = 7'd40;
    localparam logic [6:0] RST_MID  = 7'd50;
    localparam logic [6:0] RST_HIGH = 7'd60;

    localparam logic [9:0] SENSOR_DRY = 10'd850;
    localparam logic [9:0] SENSOR_WET = 10'd735;
    localparam logic [6:0] SENSOR_SPAN = 7'd115;
    localparam logic [6:0] PCT_FULL = 7'd100;
    localparam logic [7:0] LVL_HALF = 8'd127;
    localparam logic [7:0] LVL_FULL = 8'd255;
    localparam logic [7:0] LVL_TOP_BLUE = 8'd254;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] lo;
        logic [6:0] md;
        logic [6:0] hi;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PCT,
        ST_CSET,
        ST_COL,
        ST_HOLD
    } t_state;

    typedef enum logic [1:0] {
        SEG_LOW,
        SEG_MID,
        SEG_HIGH,
        SEG_TOP
    } t_seg;

endpackage

/* hw/rtl/mhc_regs.sv */
// apb-style configuration registers: mode and the three thresholds
// depends on mhc_pkg
module mhc_regs import mhc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output t_cfg              o_cfg,
    output logic              o_mode_wr
);

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr = psel && penable && pwrite;
    assign o_mode_wr = w_wr && (paddr[3:2] == REG_MODE);
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_MANUAL;
            r_cfg.lo   <= RST_LOW;
            r_cfg.md   <= RST_MID;
            r_cfg.hi   <= RST_HIGH;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_MODE: r_cfg.mode <= pwdata[1:0];
                REG_LOW:  r_cfg.lo   <= pwdata[6:0];
                REG_MID:  r_cfg.md   <= pwdata[6:0];
                REG_HIGH: r_cfg.hi   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE: prdata = {30'd0, r_cfg.mode};
            REG_LOW:  prdata = {25'd0, r_cfg.lo};
            REG_MID:  prdata = {25'd0, r_cfg.md};
            REG_HIGH: prdata = {25'd0, r_cfg.hi};
            default:  prdata = 32'd0;
        endcase
    end

endmodule

/* hw/rtl/mhc_serdiv.sv */
// bit-serial restoring divider, one quotient bit per cycle, 8 steps
// caller guarantees dividend < divisor * 256; depends on mhc_pkg
module mhc_serdiv import mhc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [13:0] i_dividend,
    input  logic [6:0]  i_divisor,
    output logic        o_done,
    output logic [7:0]  o_quot
);

    logic [6:0] r_rem;
    logic [7:0] r_sh;
    logic [6:0] r_div;
    logic [2:0] r_cnt;
    logic       r_busy;
    logic       r_done;

    logic [7:0] w_trial;
    logic [7:0] w_diff;
    logic       w_ge;

    assign w_trial = {r_rem, r_sh[7]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= r_busy && (r_cnt == 3'd7);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // remainder and low dividend bits shift left, quotient enters at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend[13:8]};
            r_sh  <= i_dividend[7:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[6:0] : w_trial[6:0];
            r_sh  <= {r_sh[6:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule

/* hw/rtl/moisture_hysteresis_controller.sv */
// top level: sample to percent, valve hysteresis, colour map to pwm compares
// depends on mhc_pkg, mhc_regs, mhc_serdiv
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+----------------------------------------
//  sample   | i_in_valid   | o_in_stall   | i_adc_sample
//  result   | o_out_valid  | i_out_stall  | o_moisture_percent, o_valve_open,
//           |              |              | o_red/green/blue_compare
//  config   | psel/penable | pready (=1)  | paddr, pwdata, prdata
//
// a request runs through ST_PCT, ST_CSET, ST_COL and ST_HOLD before the next acceptance:
// 8 serial steps for the percent and 8 for the colour pair on two divider lanes,
// plus set-up, capture and hand-off states; the result is registered on leaving ST_HOLD.
// a finished result waits in the output register while the next sample is taken.
// synchronous active-low reset closes the valve and restores the threshold defaults.
module moisture_hysteresis_controller import mhc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [9:0]        i_adc_sample,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [6:0]        o_moisture_percent,
    output logic              o_valve_open,
    output logic [7:0]        o_red_compare,
    output logic [7:0]        o_green_compare,
    output logic [7:0]        o_blue_compare,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    function automatic logic [13:0] times128(input logic [6:0] x);
        times128 = {x, 7'd0};
    endfunction

    function automatic logic [13:0] times127(input logic [6:0] x);
        times127 = {x, 7'd0} - {7'd0, x};
    endfunction

    t_cfg   w_cfg;
    logic   w_mode_wr;
    t_state r_state, n_state;
    t_seg   r_seg, w_seg;

    logic        w_in_acc, w_out_free;
    logic [9:0]  w_clamp;
    logic [6:0]  w_offs;
    logic [13:0] w_pct_num;
    logic [6:0]  w_pct;

    logic        a_start, a_done, b_start, b_done;
    logic [13:0] a_dividend, b_dividend, w_col_a, w_col_b;
    logic [6:0]  a_divisor, w_col_div;
    logic [7:0]  a_quot, b_quot;

    logic [6:0] r_pct;
    logic       r_valve;
    logic [7:0] r_res_r, r_res_g, r_res_b;
    logic [7:0] w_lvl_r, w_lvl_g, w_lvl_b;
    logic       r_o_valid;
    logic [6:0] r_o_pct;
    logic       r_o_valve;
    logic [7:0] r_o_r, r_o_g, r_o_b;

    mhc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .o_cfg     (w_cfg),
        .o_mode_wr (w_mode_wr)
    );

    assign pready = 1'b1;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_o_valid || !i_out_stall;

    // clamp and offset; the quotient of offs*100/115 stays below 101
    always_comb begin
        if (i_adc_sample > SENSOR_DRY) begin
            w_clamp = SENSOR_DRY;
        end else if (i_adc_sample < SENSOR_WET) begin
            w_clamp = SENSOR_WET;
        end else begin
            w_clamp = i_adc_sample;
        end
    end

    assign w_offs    = w_clamp[6:0] - SENSOR_WET[6:0];
    assign w_pct_num = 14'(w_offs) * 14'(PCT_FULL);
    assign w_pct     = PCT_FULL - a_quot[6:0];

    // segment choice and operands of the two colour divisions
    always_comb begin
        if (r_pct < w_cfg.lo) begin
            w_seg     = SEG_LOW;
            w_col_a   = times128(r_pct);
            w_col_b   = times127(r_pct);
            w_col_div = w_cfg.lo;
        end else if (r_pct < w_cfg.md) begin
            w_seg     = SEG_MID;
            w_col_a   = times127(r_pct - w_cfg.lo);
            w_col_b   = times128(r_pct - w_cfg.lo);
            w_col_div = w_cfg.md - w_cfg.lo;
        end else if (r_pct < w_cfg.hi) begin
            w_seg     = SEG_HIGH;
            w_col_a   = times128(w_cfg.hi - r_pct);
            w_col_b   = times127(r_pct - w_cfg.md);
            w_col_div = w_cfg.hi - w_cfg.md;
        end else begin
            w_seg     = SEG_TOP;
            w_col_a   = times127(PCT_FULL - r_pct);
            w_col_b   = times127(r_pct - w_cfg.hi);
            w_col_div = PCT_FULL - w_cfg.hi;
        end
    end

    assign a_start    = w_in_acc || (r_state == ST_CSET);
    assign a_dividend = (r_state == ST_CSET) ? w_col_a : w_pct_num;
    assign a_divisor  = (r_state == ST_CSET) ? w_col_div : SENSOR_SPAN;
    assign b_start    = (r_state == ST_CSET);
    assign b_dividend = w_col_b;

    mhc_serdiv u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (a_start),
        .i_dividend (a_dividend),
        .i_divisor  (a_divisor),
        .o_done     (a_done),
        .o_quot     (a_quot)
    );

    mhc_serdiv u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (b_start),
        .i_dividend (b_dividend),
        .i_divisor  (w_col_div),
        .o_done     (b_done),
        .o_quot     (b_quot)
    );

    // colour levels from the two quotients
    always_comb begin
        case (r_seg)
            SEG_LOW: begin
                w_lvl_r = LVL_FULL - a_quot;
                w_lvl_g = b_quot;
                w_lvl_b = 8'd0;
            end
            SEG_MID: begin
                w_lvl_r = LVL_HALF - a_quot;
                w_lvl_g = LVL_HALF + b_quot;
                w_lvl_b = 8'd0;
            end
            SEG_HIGH: begin
                w_lvl_r = 8'd0;
                w_lvl_g = LVL_HALF + a_quot;
                w_lvl_b = b_quot;
            end
            default: begin
                w_lvl_r = 8'd0;
                // last segment is empty when high sits at 100
                if (w_cfg.hi == PCT_FULL) begin
                    w_lvl_g = 8'd0;
                    w_lvl_b = LVL_TOP_BLUE;
                end else begin
                    w_lvl_g = a_quot;
                    w_lvl_b = LVL_HALF + b_quot;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_PCT;
            ST_PCT:  if (a_done) n_state = ST_CSET;
            ST_CSET: n_state = ST_COL;
            ST_COL:  if (a_done && b_done) n_state = ST_HOLD;
            ST_HOLD: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve <= 1'b0;
        end else if (w_mode_wr) begin
            r_valve <= 1'b0;
        end else if (r_state == ST_PCT && a_done) begin
            if (w_cfg.mode == MODE_HUMIDITY) begin
                if (w_pct > w_cfg.hi) begin
                    r_valve <= 1'b0;
                end else if (w_pct < w_cfg.lo) begin
                    r_valve <= 1'b1;
                end
            end else begin
                r_valve <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PCT && a_done) begin
            r_pct <= w_pct;
        end
        if (r_state == ST_CSET) begin
            r_seg <= w_seg;
        end
        if (r_state == ST_COL && a_done) begin
            r_res_r <= ~w_lvl_r;
            r_res_g <= ~w_lvl_g;
            r_res_b <= ~w_lvl_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == ST_HOLD && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_HOLD && w_out_free) begin
            r_o_pct   <= r_pct;
            r_o_valve <= r_valve;
            r_o_r     <= r_res_r;
            r_o_g     <= r_res_g;
            r_o_b     <= r_res_b;
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_moisture_percent = r_o_pct;
    assign o_valve_open       = r_o_valve;
    assign o_red_compare      = r_o_r;
    assign o_green_compare    = r_o_g;
    assign o_blue_compare     = r_o_b;

endmodule

/* hw/rtl/mhc_checker.sv */
// port-level checks for the moisture hysteresis controller, bound to the top
// depends on mhc_pkg and moisture_hysteresis_controller
module mhc_assertions import mhc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [6:0]        o_moisture_percent,
    input logic              o_valve_open,
    input logic [7:0]        o_red_compare,
    input logic [7:0]        o_green_compare,
    input logic [7:0]        o_blue_compare
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one request at a time: after acceptance the input side stalls
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sample accepted while previous request in flight");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_moisture_percent <= PCT_FULL))
        else $error("moisture percent above 100");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid
            && $stable(o_moisture_percent) && $stable(o_valve_open)
            && $stable(o_red_compare) && $stable(o_green_compare)
            && $stable(o_blue_compare)))
        else $error("stalled result changed");

endmodule

bind moisture_hysteresis_controller mhc_assertions u_mhc_assertions (.*);

/* bench/mhc_checker.sv */
`timescale 1ns / 100ps
// watches the sample, result and config channels of the moisture hysteresis controller
// keeps its own copy of the thresholds and valve bit; depends on mhc_pkg only
module mhc_checker import mhc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [9:0]        i_adc_sample,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [6:0]        i_moisture_percent,
    input  logic              i_valve_open,
    input  logic [7:0]        i_red_compare,
    input  logic [7:0]        i_green_compare,
    input  logic [7:0]        i_blue_compare,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output int                o_mismatch_count,
    output int                o_pending
);

    typedef struct packed {
        logic [6:0] pct;
        logic       valve;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_reading;

    t_cfg     cfg_copy;
    logic     valve_bit;
    t_reading reading_q[$];
    int       mismatches = 0;

    initial begin
        o_mismatch_count = 0;
        o_pending        = 0;
    end

    function automatic int unsigned sample_to_pct(logic [9:0] s);
        int unsigned v;
        v = 32'(s);
        if (v > SENSOR_DRY) v = SENSOR_DRY;
        if (v < SENSOR_WET) v = SENSOR_WET;
        return PCT_FULL - ((v - SENSOR_WET) * PCT_FULL) / SENSOR_SPAN;
    endfunction

    // four linear segments over low / mid / high / 100, returned as inverted compares
    function automatic t_reading predict_colors(int unsigned p, t_cfg c);
        int unsigned lo, md, hi, d, r, g, b;
        t_reading    res;
        lo = 32'(c.lo);
        md = 32'(c.md);
        hi = 32'(c.hi);
        if (p < lo) begin
            r = LVL_FULL - (p * (LVL_HALF + 1)) / lo;
            g = (p * LVL_HALF) / lo;
            b = 0;
        end else if (p < md) begin
            d = md - lo;
            r = LVL_HALF - ((p - lo) * LVL_HALF) / d;
            g = LVL_HALF + ((p - lo) * (LVL_HALF + 1)) / d;
            b = 0;
        end else if (p < hi) begin
            d = hi - md;
            r = 0;
            g = LVL_HALF + ((hi - p) * (LVL_HALF + 1)) / d;
            b = ((p - md) * LVL_HALF) / d;
        end else begin
            d = PCT_FULL - hi;
            r = 0;
            // high threshold at 100 leaves no width for the top segment
            if (d == 0) begin
                g = 0;
                b = LVL_TOP_BLUE;
            end else begin
                g = ((PCT_FULL - p) * LVL_HALF) / d;
                b = LVL_HALF + ((p - hi) * LVL_HALF) / d;
            end
        end
        res = '0;
        res.red   = 8'(LVL_FULL - r[7:0]);
        res.green = 8'(LVL_FULL - g[7:0]);
        res.blue  = 8'(LVL_FULL - b[7:0]);
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reading    want_r;
        int unsigned p;
        if (!i_rst_n) begin
            cfg_copy = '{mode: MODE_MANUAL, lo: RST_LOW, md: RST_MID, hi: RST_HIGH};
            valve_bit = 1'b0;
            reading_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (reading_q.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want_r = reading_q.pop_front();
                    check_field("moisture_percent", 32'(want_r.pct),
                                32'(i_moisture_percent));
                    check_field("valve_open", 32'(want_r.valve), 32'(i_valve_open));
                    check_field("red_compare", 32'(want_r.red), 32'(i_red_compare));
                    check_field("green_compare", 32'(want_r.green),
                                32'(i_green_compare));
                    check_field("blue_compare", 32'(want_r.blue), 32'(i_blue_compare));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                p = sample_to_pct(i_adc_sample);
                // "above high" wins over "below low" when thresholds cross
                if (cfg_copy.mode == MODE_HUMIDITY) begin
                    if (p > cfg_copy.hi) valve_bit = 1'b0;
                    else if (p < cfg_copy.lo) valve_bit = 1'b1;
                end else begin
                    valve_bit = 1'b0;
                end
                want_r = predict_colors(p, cfg_copy);
                want_r.pct = p[6:0];
                want_r.valve = valve_bit;
                reading_q.push_back(want_r);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_AW-1:2])
                    REG_MODE: begin
                        cfg_copy.mode = i_pwdata[1:0];
                        valve_bit = 1'b0;
                    end
                    REG_LOW:  cfg_copy.lo = i_pwdata[6:0];
                    REG_MID:  cfg_copy.md = i_pwdata[6:0];
                    REG_HIGH: cfg_copy.hi = i_pwdata[6:0];
                    default: ;
                endcase
            end
        end
        o_pending <= reading_q.size();
        o_mismatch_count <= mismatches;
    end

endmodule

/* bench/tb_moisture_hysteresis_controller.sv */
`timescale 1ns / 100ps
// stimulus and verdict for the moisture hysteresis controller
// depends on mhc_pkg, the block itself and mhc_checker
module tb_moisture_hysteresis_controller;
    import mhc_pkg::*;

    localparam logic [1:0] MODE_TIMED  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_PCT   = 17;
    localparam int HOLD_OFF   = 300;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 50;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [9:0]        i_adc_sample;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [6:0]        o_moisture_percent;
    logic              o_valve_open;
    logic [7:0]        o_red_compare;
    logic [7:0]        o_green_compare;
    logic [7:0]        o_blue_compare;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int mismatch_count;
    int pending_count;
    bit quiet = 1'b0;
    bit hold_off_req = 1'b0;
    int sent = 0;
    int walk = 790;

    moisture_hysteresis_controller u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_adc_sample(i_adc_sample),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_moisture_percent(o_moisture_percent), .o_valve_open(o_valve_open),
        .o_red_compare(o_red_compare), .o_green_compare(o_green_compare),
        .o_blue_compare(o_blue_compare),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mhc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_adc_sample(i_adc_sample),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_moisture_percent(o_moisture_percent), .i_valve_open(o_valve_open),
        .i_red_compare(o_red_compare), .i_green_compare(o_green_compare),
        .i_blue_compare(o_blue_compare),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_mismatch_count(mismatch_count), .o_pending(pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                for (int n = 0; n < HOLD_OFF; n++) begin
                    i_out_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end else begin
                i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic send_sample(input logic [9:0] s);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_adc_sample <= s;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_thresholds(input int lo, input int md, input int hi);
        reg_write(REG_LOW, lo);
        reg_write(REG_MID, md);
        reg_write(REG_HIGH, hi);
    endtask

    // mostly a slow drift across the sensor span so the valve crosses both thresholds
    function automatic logic [9:0] next_sample();
        case ($urandom_range(9))
            0, 1: return 10'($urandom_range(1023));
            default: begin
                walk = walk + $urandom_range(16) - 8;
                if (walk < 725) walk = 725;
                if (walk > 860) walk = 860;
                return 10'(walk);
            end
        endcase
    endfunction

    task automatic random_config();
        int lo, md, hi;
        case ($urandom_range(9))
            7: begin
                lo = $urandom_range(97, 1);
                md = $urandom_range(98, 2);
                hi = $urandom_range(99, 3);
            end
            8: begin
                if ($urandom_range(1)) begin
                    lo = 1; md = 2; hi = 3;
                end else begin
                    lo = 97; md = 98; hi = 99;
                end
            end
            default: begin
                lo = $urandom_range(97, 1);
                md = $urandom_range(98, lo + 1);
                hi = $urandom_range(99, md + 1);
            end
        endcase
        if ($urandom_range(9) == 9) hi = 100;
        if ($urandom_range(3) != 0) reg_write(REG_LOW, lo);
        if ($urandom_range(3) != 0) reg_write(REG_MID, md);
        if ($urandom_range(3) != 0) reg_write(REG_HIGH, hi);
        if ($urandom_range(9) < 7) begin
            if ($urandom_range(9) < 6) reg_write(REG_MODE, 32'(MODE_HUMIDITY));
            else reg_write(REG_MODE, $urandom_range(3));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_adc_sample = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset thresholds, manual mode: clamp edges and all-zero / all-one codes
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd735);
        send_sample(10'd851);
        finish_phase();

        // hysteresis: open when dry, hold, close when wet, open again when dry
        reg_write(REG_MODE, 32'(MODE_HUMIDITY));
        send_sample(10'd850);
        send_sample(10'd800);
        send_sample(10'd735);
        send_sample(10'd850);
        finish_phase();
        // writing the mode again closes an open valve
        reg_write(REG_MODE, 32'(MODE_HUMIDITY));
        send_sample(10'd800);
        finish_phase();

        reg_write(REG_MODE, 32'(MODE_TIMED));
        send_sample(10'd850);
        send_sample(10'd735);
        finish_phase();
        reg_write(REG_MODE, 32'(MODE_UNUSED));
        send_sample(10'd850);
        finish_phase();

        // high threshold at 100: empty top segment
        reg_write(REG_MODE, 32'(MODE_HUMIDITY));
        set_thresholds(40, 50, 100);
        send_sample(10'd735);
        send_sample(10'd737);
        finish_phase();

        // thresholds out of order
        set_thresholds(90, 20, 10);
        send_sample(10'd850);
        send_sample(10'd735);
        send_sample(10'd760);
        finish_phase();

        set_thresholds(1, 2, 3);
        send_sample(10'd850);
        send_sample(10'd849);
        send_sample(10'd848);
        send_sample(10'd847);
        finish_phase();

        set_thresholds(97, 98, 99);
        send_sample(10'd737);
        send_sample(10'd738);
        send_sample(10'd739);
        finish_phase();

        for (int ph = 0; ph < PHASES; ph++) begin
            random_config();
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (ph == 3 && k == 10) hold_off_req = 1'b1;
                quiet = (ph == 6);
                send_sample(next_sample());
            end
            quiet = 1'b0;
            finish_phase();
        end

        repeat (40) @(negedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/mhc_pkg.sv
hw/rtl/mhc_regs.sv
hw/rtl/mhc_serdiv.sv
hw/rtl/moisture_hysteresis_controller.sv
hw/rtl/mhc_checker.sv
bench/mhc_checker.sv
bench/tb_moisture_hysteresis_controller.sv
